// ----- hw/rtl/mcsd_pkg.sv -----
// Package for the multi-click switch detector.
// Holds the result type, event codes and reset constants; depends on nothing.
package mcsd_pkg;

    localparam int unsigned WINDOW_WIDTH = 16;
    localparam int unsigned CLICK_WIDTH  = 2;

    localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = 16'd25;

    typedef enum logic {
        EV_PRESS   = 1'b0,
        EV_RELEASE = 1'b1
    } t_event;

    localparam logic [CLICK_WIDTH-1:0] CLICK_NONE   = 2'd0;
    localparam logic [CLICK_WIDTH-1:0] CLICK_SINGLE = 2'd1;
    localparam logic [CLICK_WIDTH-1:0] CLICK_DOUBLE = 2'd2;
    localparam logic [CLICK_WIDTH-1:0] CLICK_TRIPLE = 2'd3;

    typedef struct packed {
        logic                   valid;
        t_event                 event_res;
        logic [CLICK_WIDTH-1:0] click_count;
    } t_result;

endpackage

// ----- hw/rtl/mcsd_intf.sv -----
// Handshake interfaces for the multi-click switch detector channels.
// Depends on mcsd_pkg for field widths.
interface mcsd_level_if;
    logic valid;
    logic ready;
    logic level;
    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

interface mcsd_event_if;
    logic                             valid;
    logic                             ready;
    logic                             event_res;
    logic [mcsd_pkg::CLICK_WIDTH-1:0] click_count;
    modport source (output valid, output event_res, output click_count, input ready);
    modport sink   (input valid, input event_res, input click_count, output ready);
endinterface

interface mcsd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mcsd_pkg::WINDOW_WIDTH-1:0] window_ticks;
    modport source (output valid, output window_ticks, input ready);
    modport sink   (input valid, input window_ticks, output ready);
endinterface

// ----- hw/rtl/mcsd_core.sv -----
// Click classification state: window register, age counter and click tracking.
// Depends on mcsd_pkg; produces at most one result per accepted item.
module mcsd_core #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mcsd_pkg::WINDOW_WIDTH-1:0] i_cfg_window,
    input  logic                              i_accept,
    input  logic                              i_level,
    output mcsd_pkg::t_result                 o_push
);

    localparam int unsigned EW = (COUNT_WIDTH > mcsd_pkg::WINDOW_WIDTH) ?
                                 COUNT_WIDTH : mcsd_pkg::WINDOW_WIDTH;
    localparam logic [63:0] CMAX64 = (64'd1 << COUNT_WIDTH) - 64'd1;
    localparam logic [63:0] RST64  = (64'(mcsd_pkg::WINDOW_RESET) < CMAX64) ?
                                     64'(mcsd_pkg::WINDOW_RESET) : CMAX64;
    localparam logic [COUNT_WIDTH-1:0] AGE_RESET = RST64[COUNT_WIDTH-1:0];
    localparam logic [EW-1:0]          CMAX      = CMAX64[EW-1:0];

    logic [mcsd_pkg::WINDOW_WIDTH-1:0] r_window;
    logic                              r_prev;
    logic [mcsd_pkg::CLICK_WIDTH-1:0]  r_active;
    logic [COUNT_WIDTH-1:0]            r_age;
    logic                              r_prior_short;

    logic [mcsd_pkg::CLICK_WIDTH-1:0]  n_active;
    logic [COUNT_WIDTH-1:0]            n_age;
    logic                              n_prior_short;

    logic [EW-1:0]          win_ext;
    logic [EW-1:0]          eff_ext;
    logic [COUNT_WIDTH-1:0] eff_win;
    logic [COUNT_WIDTH-1:0] age_inc;
    logic                   is_press;
    logic                   is_release;
    logic                   short_gap;

    always_comb begin
        win_ext = EW'(r_window);
        eff_ext = (win_ext < CMAX) ? win_ext : CMAX;
        eff_win = eff_ext[COUNT_WIDTH-1:0];
        age_inc = (r_age < eff_win) ? (r_age + COUNT_WIDTH'(1)) : r_age;
        short_gap  = (age_inc < eff_win);
        is_press   = i_level && r_prev && (r_active == mcsd_pkg::CLICK_NONE);
        is_release = !i_level && !r_prev;

        n_active      = r_active;
        n_age         = age_inc;
        n_prior_short = r_prior_short;
        o_push.valid       = 1'b0;
        o_push.event_res   = mcsd_pkg::EV_PRESS;
        o_push.click_count = r_active;

        if (is_press) begin
            if (short_gap) begin
                n_active = r_prior_short ? mcsd_pkg::CLICK_TRIPLE : mcsd_pkg::CLICK_DOUBLE;
            end else begin
                n_active = mcsd_pkg::CLICK_SINGLE;
            end
            n_prior_short      = short_gap;
            n_age              = '0;
            o_push.valid       = i_accept;
            o_push.click_count = n_active;
        end else if (is_release) begin
            n_active         = mcsd_pkg::CLICK_NONE;
            o_push.valid     = i_accept && (r_active != mcsd_pkg::CLICK_NONE);
            o_push.event_res = mcsd_pkg::EV_RELEASE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window      <= mcsd_pkg::WINDOW_RESET;
            r_prev        <= 1'b0;
            r_active      <= mcsd_pkg::CLICK_NONE;
            r_age         <= AGE_RESET;
            r_prior_short <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_window;
            end
            if (i_accept) begin
                r_prev        <= i_level;
                r_active      <= n_active;
                r_age         <= n_age;
                r_prior_short <= n_prior_short;
            end
        end
    end

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> (o_push.click_count != mcsd_pkg::CLICK_NONE))
        else $error("result with no click count");

    a_press_clears_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && is_press) |=> (r_age == '0))
        else $error("age not cleared after press");

    a_release_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.valid && o_push.event_res == mcsd_pkg::EV_RELEASE)
            |=> (r_active == mcsd_pkg::CLICK_NONE))
        else $error("click still active after release");

endmodule

// ----- hw/rtl/mcsd_outbuf.sv -----
// Output register with a skid stage for the detector's result items.
// Depends on mcsd_pkg for the result type.
module mcsd_outbuf (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mcsd_pkg::t_result                i_push,
    output logic                             o_ready,
    output logic                             o_valid,
    output logic                             o_event_res,
    output logic [mcsd_pkg::CLICK_WIDTH-1:0] o_click_count,
    input  logic                             i_ready
);

    mcsd_pkg::t_result r_main;
    mcsd_pkg::t_result r_skid;

    assign o_ready       = !r_skid.valid;
    assign o_valid       = r_main.valid;
    assign o_event_res   = r_main.event_res;
    assign o_click_count = r_main.click_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main.valid <= 1'b0;
            r_skid.valid <= 1'b0;
        end else if (i_ready || !r_main.valid) begin
            r_main       <= r_skid.valid ? r_skid : i_push;
            r_skid.valid <= 1'b0;
        end else if (i_push.valid) begin
            r_skid <= i_push;
        end
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid.valid |-> r_main.valid)
        else $error("skid stage holds an item ahead of the output");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid.valid) |-> $past(i_push.valid && r_main.valid && !i_ready))
        else $error("skid stage filled without a stall");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid.valid |-> !i_push.valid)
        else $error("item pushed while skid stage full");

endmodule

// ----- hw/rtl/multi_click_switch_detector.sv -----
// Multi-click switch detector: sorts debounced presses into single, double, triple clicks.
// Result path: the result of an accepted item is registered in the output register, or in the skid stage on a stall.
// Throughput: one item per cycle while the skid stage is empty; it holds one result while the output stalls.
// Set by: the state update and the skid-buffered output register.
// Reset (synchronous, active low): window 25 ticks, no click active, output empty.
// Depends on mcsd_pkg, the interfaces in mcsd_intf, mcsd_core and mcsd_outbuf.
module multi_click_switch_detector #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mcsd_cfg_if.sink            i_cfg,
    mcsd_level_if.sink          i_in,
    mcsd_event_if.source        o_out
);

    mcsd_pkg::t_result push;
    logic              buf_ready;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = buf_ready;

    mcsd_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_window (i_cfg.window_ticks),
        .i_accept     (i_in.valid && buf_ready),
        .i_level      (i_in.level),
        .o_push       (push)
    );

    mcsd_outbuf u_outbuf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_ready       (buf_ready),
        .o_valid       (o_out.valid),
        .o_event_res   (o_out.event_res),
        .o_click_count (o_out.click_count),
        .i_ready       (o_out.ready)
    );

endmodule

// ----- bench/multi_click_switch_detector_test.sv -----
// Self-checking testbench for the multi-click switch detector.
// Drives switch samples and repeat-window writes, predicts click events and checks each one.
// Depends on mcsd_pkg, the channel interfaces in mcsd_intf and the multi_click_switch_detector top.
module multi_click_switch_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COUNT_WIDTH = 16;
    localparam longint unsigned AGE_MAX = (64'd1 << COUNT_WIDTH) - 1;

    typedef struct packed {
        mcsd_pkg::t_event                 kind;
        logic [mcsd_pkg::CLICK_WIDTH-1:0] clicks;
    } t_click_event;

    logic i_clk;
    logic i_rst_n;

    mcsd_cfg_if   cfg_ch();
    mcsd_level_if level_ch();
    mcsd_event_if event_ch();

    multi_click_switch_detector #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch.sink),
        .i_in   (level_ch.sink),
        .o_out  (event_ch.source)
    );

    // Predicted detector state.
    longint unsigned                  window_q;
    longint unsigned                  age_q;
    logic                             last_level_q;
    logic [mcsd_pkg::CLICK_WIDTH-1:0] held_clicks_q;
    logic                             repeat_run_q;

    t_click_event pending_events[$];

    int  error_count;
    int  items_sent;
    int  windows_written;
    int  presses_seen;
    int  releases_seen;
    int  class_seen[4];
    bit  steady;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Timeout: results still outstanding after the time limit.");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic flag_error(input string msg);
        if (error_count < 10) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
        error_count++;
    endtask

    function automatic void predict_tick(input logic lvl);
        longint unsigned                  win;
        logic                             gap_short;
        logic [mcsd_pkg::CLICK_WIDTH-1:0] cnt;
        t_click_event                     ev;
        win = (window_q > AGE_MAX) ? AGE_MAX : window_q;
        if (age_q < win) begin
            age_q++;
        end
        if (lvl && last_level_q) begin
            if (held_clicks_q == mcsd_pkg::CLICK_NONE) begin
                gap_short = (age_q < win);
                if (gap_short) begin
                    cnt = repeat_run_q ? mcsd_pkg::CLICK_TRIPLE : mcsd_pkg::CLICK_DOUBLE;
                end else begin
                    cnt = mcsd_pkg::CLICK_SINGLE;
                end
                held_clicks_q = cnt;
                repeat_run_q = gap_short;
                age_q = '0;
                ev.kind = mcsd_pkg::EV_PRESS;
                ev.clicks = cnt;
                pending_events.push_back(ev);
            end
        end else if (!lvl && !last_level_q) begin
            if (held_clicks_q != mcsd_pkg::CLICK_NONE) begin
                ev.kind = mcsd_pkg::EV_RELEASE;
                ev.clicks = held_clicks_q;
                pending_events.push_back(ev);
            end
            held_clicks_q = mcsd_pkg::CLICK_NONE;
        end
        last_level_q = lvl;
    endfunction

    task automatic send_level(input logic lvl);
        while (!steady && $urandom_range(99) < 33) begin
            level_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        level_ch.valid <= 1'b1;
        level_ch.level <= lvl;
        do @(posedge i_clk); while (!level_ch.ready);
        predict_tick(lvl);
        items_sent++;
    endtask

    // Stops the sender, waits for every predicted event and then waits on
    // so that a tick that produced nothing has also left the pipeline.
    task automatic let_results_drain();
        int guard;
        guard = 0;
        level_ch.valid <= 1'b0;
        while (pending_events.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [mcsd_pkg::WINDOW_WIDTH-1:0] ticks);
        let_results_drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.window_ticks <= ticks;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        window_q = 64'(ticks);
        windows_written++;
    endtask

    task automatic send_run(input logic lvl, input int len);
        repeat (len) send_level(lvl);
    endtask

    // Mostly well-formed clicks whose release lengths straddle the window, plus noise
    // and bounced presses.
    task automatic run_click_phase(input int n_items);
        int stop_at;
        int pick;
        int low_len;
        int base;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                send_run(1'b1, $urandom_range(2, 6));
                case ($urandom_range(2))
                    0: low_len = $urandom_range(2, 4);
                    1: begin
                        base = (window_q > 40) ? 40 : int'(window_q);
                        low_len = base - 3 + $urandom_range(5);
                    end
                    default: low_len = $urandom_range(2, 40);
                endcase
                if (low_len < 2) begin
                    low_len = 2;
                end
                send_run(1'b0, low_len);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 6)) send_level(1'($urandom_range(1)));
            end else begin
                send_level(1'b1);
                send_level(1'b0);
                send_run(1'b1, $urandom_range(1, 3));
                send_level(1'b0);
            end
        end
    endtask

    task automatic test_reset_clicks();
        send_run(1'b1, 3);
        send_run(1'b0, 3);
        send_run(1'b1, 2);
        send_run(1'b0, 2);
        send_run(1'b1, 2);
        send_run(1'b0, 2);
    endtask

    task automatic test_unpaired_levels();
        send_level(1'b1);
        send_level(1'b0);
        send_level(1'b1);
        send_level(1'b0);
    endtask

    task automatic test_window_sweep();
        logic [mcsd_pkg::WINDOW_WIDTH-1:0] windows[6];
        windows = '{16'd0, 16'd1, 16'd6, 16'hFFFF, 16'd3, 16'd25};
        foreach (windows[i]) begin
            write_window(windows[i]);
            run_click_phase(40);
        end
    endtask

    task automatic test_steady_stream();
        write_window(16'd12);
        steady = 1'b1;
        run_click_phase(40);
        let_results_drain();
        steady = 1'b0;
    endtask

    task automatic test_paused_sender();
        write_window(16'd40);
        run_click_phase(20);
        let_results_drain();
        run_click_phase(20);
    endtask

    initial begin
        event_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            event_ch.ready <= steady || ($urandom_range(99) >= 33);
        end
    end

    initial begin
        t_click_event want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && event_ch.valid && event_ch.ready) begin
                if (pending_events.size() == 0) begin
                    flag_error($sformatf("unexpected event kind=%0d clicks=%0d",
                                         event_ch.event_res, event_ch.click_count));
                end else begin
                    want = pending_events.pop_front();
                    if (event_ch.event_res !== want.kind) begin
                        flag_error($sformatf("event kind expected %s, got %0d",
                                             want.kind.name(), event_ch.event_res));
                    end else if (event_ch.click_count !== want.clicks) begin
                        flag_error($sformatf("%s click count expected %0d, got %0d",
                                             want.kind.name(), want.clicks,
                                             event_ch.click_count));
                    end else begin
                        if (want.kind == mcsd_pkg::EV_PRESS) begin
                            presses_seen++;
                        end else begin
                            releases_seen++;
                        end
                        class_seen[want.clicks]++;
                    end
                end
            end
        end
    end

    initial begin
        error_count = 0;
        items_sent = 0;
        windows_written = 0;
        presses_seen = 0;
        releases_seen = 0;
        class_seen = '{0, 0, 0, 0};
        steady = 1'b0;
        window_q = 64'(mcsd_pkg::WINDOW_RESET);
        age_q = (window_q > AGE_MAX) ? AGE_MAX : window_q;
        last_level_q = 1'b0;
        held_clicks_q = mcsd_pkg::CLICK_NONE;
        repeat_run_q = 1'b0;

        i_rst_n <= 1'b0;
        level_ch.valid <= 1'b0;
        level_ch.level <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.window_ticks <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_clicks();
        test_unpaired_levels();
        test_window_sweep();
        test_steady_stream();
        test_paused_sender();

        let_results_drain();
        if (pending_events.size() != 0) begin
            flag_error($sformatf("%0d predicted events never arrived", pending_events.size()));
        end

        $display("Sent %0d switch samples over %0d window writes, including 0 and 65535.",
                 items_sent, windows_written);
        $display("Checked %0d presses and %0d releases: %0d single, %0d double, %0d triple.",
                 presses_seen, releases_seen, class_seen[1], class_seen[2], class_seen[3]);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
